// ----- rtl/atom_pick_and_selection_order_assert.svh -----
// Assertion macros shared by the atom pick and selection order design.
`ifndef ATOM_PICK_AND_SELECTION_ORDER_ASSERT_SVH
`define ATOM_PICK_AND_SELECTION_ORDER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define APSO_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define APSO_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/apso_pkg.sv -----
// Package with types, constants and helpers of the atom pick and selection order block.
package apso_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int FRAME_W       = 10;
  localparam int COORD_W       = 16;
  localparam int RAD_W         = 12;
  localparam int ORD_W         = 10;
  localparam int RANK_W        = 11;
  localparam int POS_W         = 2 * COORD_W;
  localparam int ATTR_W        = RAD_W + ORD_W + 1;
  localparam int BASE_W        = FRAME_W + CNT_W + 1;
  localparam int MSTEP_W       = $clog2(FRAME_W);
  localparam int CFG_IDX_W     = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1024);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_PICK   = 2'd1,
    CMD_REGION = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATOM_COUNT    = 2'd0,
    CFG_FRAME_COUNT   = 2'd1,
    CFG_CURRENT_FRAME = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SCAN_PICK   = 2'd0,
    SCAN_REGION = 2'd1,
    SCAN_RENUM  = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic [1:0]                command;
    logic [IDX_W-1:0]          entry_index;
    logic signed [COORD_W-1:0] atom_x;
    logic signed [COORD_W-1:0] atom_y;
    logic [RAD_W-1:0]          atom_radius;
    logic [ORD_W-1:0]          atom_depth_order;
    logic                      atom_hidden;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } apso_in_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  hit_atom;
    logic [RANK_W-1:0] hit_rank;
    logic [CNT_W-1:0]  selected_count;
  } apso_out_t;

  typedef struct packed {
    logic       clr_en;
    logic       load;
    logic       mod_run;
    logic       base_load;
    logic       scan_start;
    scan_mode_e scan_mode;
    logic       fetch;
    logic       resolve;
  } apso_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       mod_last;
    logic       scan_done;
    logic       have;
    logic       old_nz;
    logic [1:0] command;
  } apso_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v >= COUNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- rtl/atom_pick_and_selection_order.sv -----
// Top level of the atom pick and selection order block.
//
//   Channel  Handshake            Payload
//   in       start, busy          cmd_i   (apso_in_t)
//   out      done_o strobe        result_o (apso_out_t)
//   config   cfg_we_i, cfg_idx_i  cfg_wdata_i
//
// A write goes from start straight to the result beat, with no scan.
// A region select or a pick first reduces the current frame modulo the frame count,
// then scans the frame atoms at one entry per cycle through the single read port
// of the rank RAM; a pick that deselects then runs a second scan to renumber the ranks.
// After reset a clearing pass zeroes all 1024 rank entries while busy is high.
// The result beat lasts one cycle and the receiver cannot stall it.
module atom_pick_and_selection_order import apso_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  apso_in_t             cmd_i,
  output logic                 busy,
  output logic                 done_o,
  output apso_out_t            result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i
);

  `include "atom_pick_and_selection_order_assert.svh"

  apso_cmd_t  ctl_cmd;
  apso_stat_t dp_stat;

  apso_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (cmd_i.command),
    .stat_i    (dp_stat),
    .cmd_o     (ctl_cmd),
    .busy      (busy),
    .done_o    (done_o)
  );

  apso_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (cmd_i),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .result_o    (result_o)
  );

  `APSO_ASSERT_SAME(a_done_busy, clk_i, rst_ni, done_o, busy, "result beat while idle")
  `APSO_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "accepted item not taken")
  `APSO_ASSERT_SAME(a_rank_le_count, clk_i, rst_ni, done_o,
                    result_o.hit_rank <= result_o.selected_count, "rank above count")
  `APSO_ASSERT_SAME(a_miss_zero, clk_i, rst_ni, done_o && !result_o.found,
                    (result_o.hit_atom == '0) && (result_o.hit_rank == '0), "miss with hit data")

endmodule

// ----- rtl/apso_ram.sv -----
// Generic single write port RAM with one registered read port.
module apso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/apso_datapath.sv -----
// Datapath: atom tables, frame base unit, scan pipeline and selection bookkeeping.
module apso_datapath import apso_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  input  apso_in_t             item_i,
  input  apso_cmd_t            cmd_i,
  output apso_stat_t           stat_o,
  output apso_out_t            result_o
);

  logic [CNT_W-1:0]   atom_count_q, frame_count_q;
  logic [FRAME_W-1:0] current_frame_q;
  apso_in_t           item_q;
  logic [ADDR_W-1:0]  clr_q;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [MSTEP_W-1:0] mstep_q;
  logic [BASE_W-1:0]  base_q;
  logic               active_q;
  logic [CNT_W-1:0]   idx_q;
  scan_mode_e         mode_q;
  logic               v1_q, v2_q;
  logic [IDX_W-1:0]   i1_q, i2_q;
  logic [ADDR_W-1:0]  a1_q, bt_q;
  logic [ORD_W-1:0]   ord2_q, best_ord_q;
  logic [2*COORD_W+1:0] dx2_q, dy2_q;
  logic [2*RAD_W-1:0] r2_q;
  logic               have_q, found_q;
  logic [IDX_W-1:0]   best_q, hit_q;
  logic [RANK_W-1:0]  hit_rank_q, old_q;
  logic [CNT_W-1:0]   total_q, total_d;

  logic [CNT_W-1:0]   fc;
  logic [CNT_W:0]     shifted;
  logic [BASE_W:0]    t_full;
  logic               issue_ok;
  logic [ADDR_W-1:0]  bt;
  logic [POS_W-1:0]   pos_rd;
  logic [ATTR_W-1:0]  attr_rd;
  logic [RANK_W-1:0]  rank_rd;
  logic               ent_we;
  logic [ADDR_W-1:0]  ent_addr;
  logic               rank_we;
  logic [ADDR_W-1:0]  rank_waddr, rank_raddr;
  logic [RANK_W-1:0]  rank_wdata;
  logic signed [COORD_W-1:0] ax, ay;
  logic signed [COORD_W:0]   dxs, dys;
  logic [COORD_W:0]   dx, dy;
  logic               in_box, pick_hit;
  logic [2*COORD_W+2:0] dist2;

  assign fc      = (frame_count_q == '0) ? CNT_W'(1) : frame_count_q;
  assign shifted = {rem_q, current_frame_q[MSTEP_W'(FRAME_W-1) - mstep_q]};
  assign rem_d   = (shifted >= {1'b0, fc}) ? CNT_W'(shifted - {1'b0, fc}) : shifted[CNT_W-1:0];
  assign t_full  = {1'b0, base_q} + (BASE_W+1)'(idx_q);
  assign issue_ok = active_q && (idx_q < atom_count_q) && (t_full < (BASE_W+1)'(TABLE_ENTRIES));
  assign bt      = ADDR_W'(base_q + BASE_W'(best_q));
  assign ent_we  = cmd_i.load && (item_i.command == CMD_WRITE) &&
                   ({1'b0, item_i.entry_index} < (IDX_W+1)'(TABLE_ENTRIES));
  assign ent_addr = ADDR_W'(item_i.entry_index);
  assign rank_raddr = cmd_i.fetch ? bt : t_full[ADDR_W-1:0];

  assign ax     = pos_rd[COORD_W-1:0];
  assign ay     = pos_rd[POS_W-1:COORD_W];
  assign dxs    = (COORD_W+1)'(item_q.point_x) - (COORD_W+1)'(ax);
  assign dys    = (COORD_W+1)'(item_q.point_y) - (COORD_W+1)'(ay);
  assign dx     = (dxs < 0) ? (COORD_W+1)'(-dxs) : (COORD_W+1)'(dxs);
  assign dy     = (dys < 0) ? (COORD_W+1)'(-dys) : (COORD_W+1)'(dys);
  assign in_box = (ax >= item_q.point_x) && (ax <= item_q.end_x) &&
                  (ay >= item_q.point_y) && (ay <= item_q.end_y);
  assign dist2  = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign pick_hit = v2_q && (dist2 <= (2*COORD_W+3)'(r2_q));

  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = a1_q;
    rank_wdata = '0;
    total_d    = total_q;
    if (cmd_i.clr_en) begin
      rank_we    = 1'b1;
      rank_waddr = clr_q;
    end else if (ent_we) begin
      rank_we    = 1'b1;
      rank_waddr = ent_addr;
    end else if (cmd_i.resolve) begin
      rank_we    = 1'b1;
      rank_waddr = bt_q;
      if (rank_rd != '0) begin
        total_d = (total_q == '0) ? total_q : total_q - CNT_W'(1);
      end else begin
        total_d    = sat_inc(total_q);
        rank_wdata = RANK_W'(total_d);
      end
    end else if (v1_q && (mode_q == SCAN_REGION) && in_box && (rank_rd == '0)) begin
      rank_we    = 1'b1;
      total_d    = sat_inc(total_q);
      rank_wdata = RANK_W'(total_d);
    end else if (v1_q && (mode_q == SCAN_RENUM) && (a1_q != bt_q) && (rank_rd > old_q)) begin
      rank_we    = 1'b1;
      rank_wdata = rank_rd - RANK_W'(1);
    end
  end

  apso_ram #(.WIDTH(POS_W), .DEPTH(TABLE_ENTRIES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_addr),
    .wdata_i ({item_i.atom_y, item_i.atom_x}),
    .raddr_i (t_full[ADDR_W-1:0]),
    .rdata_o (pos_rd)
  );

  apso_ram #(.WIDTH(ATTR_W), .DEPTH(TABLE_ENTRIES)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_addr),
    .wdata_i ({item_i.atom_hidden, item_i.atom_depth_order, item_i.atom_radius}),
    .raddr_i (t_full[ADDR_W-1:0]),
    .rdata_o (attr_rd)
  );

  apso_ram #(.WIDTH(RANK_W), .DEPTH(TABLE_ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (rank_wdata),
    .raddr_i (rank_raddr),
    .rdata_o (rank_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q    <= CNT_W'(1);
      frame_count_q   <= CNT_W'(1);
      current_frame_q <= '0;
      total_q         <= '0;
      clr_q           <= '0;
      active_q        <= 1'b0;
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      mode_q          <= SCAN_PICK;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ATOM_COUNT:    atom_count_q    <= cfg_wdata_i;
          CFG_FRAME_COUNT:   frame_count_q   <= cfg_wdata_i;
          CFG_CURRENT_FRAME: current_frame_q <= cfg_wdata_i[FRAME_W-1:0];
          default: ;
        endcase
      end
      total_q <= total_d;
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.scan_start) begin
        active_q <= 1'b1;
        mode_q   <= cmd_i.scan_mode;
      end else if (!issue_ok) begin
        active_q <= 1'b0;
      end
      v1_q <= issue_ok;
      v2_q <= v1_q && (mode_q == SCAN_PICK) && !attr_rd[ATTR_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q     <= item_i;
      rem_q      <= '0;
      mstep_q    <= '0;
      have_q     <= 1'b0;
      found_q    <= 1'b0;
      hit_q      <= '0;
      hit_rank_q <= '0;
      best_q     <= '0;
      best_ord_q <= '0;
    end
    if (cmd_i.mod_run) begin
      rem_q   <= rem_d;
      mstep_q <= mstep_q + MSTEP_W'(1);
    end
    if (cmd_i.base_load) begin
      base_q <= BASE_W'(rem_q[FRAME_W-1:0] * atom_count_q);
    end
    if (cmd_i.scan_start) begin
      idx_q <= '0;
    end else if (issue_ok) begin
      idx_q <= idx_q + CNT_W'(1);
    end
    i1_q   <= idx_q[IDX_W-1:0];
    a1_q   <= t_full[ADDR_W-1:0];
    i2_q   <= i1_q;
    ord2_q <= attr_rd[RAD_W+ORD_W-1:RAD_W];
    dx2_q  <= dx * dx;
    dy2_q  <= dy * dy;
    r2_q   <= attr_rd[RAD_W-1:0] * attr_rd[RAD_W-1:0];
    if (pick_hit && (!have_q || (ord2_q < best_ord_q))) begin
      have_q     <= 1'b1;
      best_q     <= i2_q;
      best_ord_q <= ord2_q;
    end
    if (v1_q && (mode_q == SCAN_REGION) && in_box) begin
      found_q <= 1'b1;
    end
    if (cmd_i.fetch) begin
      bt_q <= bt;
    end
    if (cmd_i.resolve) begin
      old_q      <= rank_rd;
      found_q    <= 1'b1;
      hit_q      <= best_q;
      hit_rank_q <= (rank_rd != '0) ? '0 : RANK_W'(total_d);
    end
  end

  assign stat_o.clr_last  = (clr_q == ADDR_W'(TABLE_ENTRIES - 1));
  assign stat_o.mod_last  = (mstep_q == MSTEP_W'(FRAME_W - 1));
  assign stat_o.scan_done = !active_q && !v1_q && !v2_q;
  assign stat_o.have      = have_q;
  assign stat_o.old_nz    = (rank_rd != '0);
  assign stat_o.command   = item_q.command;

  assign result_o.found          = found_q;
  assign result_o.hit_atom       = hit_q;
  assign result_o.hit_rank       = hit_rank_q;
  assign result_o.selected_count = total_q;

endmodule

// ----- rtl/apso_ctrl.sv -----
// Controller state machine sequencing the clearing pass, commands and scans.
module apso_ctrl import apso_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] command_i,
  input  apso_stat_t stat_i,
  output apso_cmd_t  cmd_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_MOD     = 9'b000000100,
    S_BASE    = 9'b000001000,
    S_SCAN    = 9'b000010000,
    S_FETCH   = 9'b000100000,
    S_RESOLVE = 9'b001000000,
    S_RENUM   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.scan_mode = SCAN_PICK;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = ((command_i == CMD_PICK) || (command_i == CMD_REGION)) ? S_MOD : S_DONE;
        end
      end
      S_MOD: begin
        cmd_o.mod_run = 1'b1;
        if (stat_i.mod_last) state_d = S_BASE;
      end
      S_BASE: begin
        cmd_o.base_load  = 1'b1;
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_mode  = (stat_i.command == CMD_REGION) ? SCAN_REGION : SCAN_PICK;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = ((stat_i.command == CMD_PICK) && stat_i.have) ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        if (stat_i.old_nz) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_mode  = SCAN_RENUM;
          state_d = S_RENUM;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RENUM: begin
        if (stat_i.scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the atom pick and selection order block, with a built-in predictor.
module testbench;
  import apso_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  apso_in_t             cmd_i = '0;
  logic                 busy;
  logic                 done_o;
  apso_out_t            result_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CNT_W-1:0]     cfg_wdata_i = '0;

  atom_pick_and_selection_order uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [COORD_W-1:0] atom_x_tab [TABLE_ENTRIES];
  logic signed [COORD_W-1:0] atom_y_tab [TABLE_ENTRIES];
  logic [RAD_W-1:0]          radius_tab [TABLE_ENTRIES];
  logic [ORD_W-1:0]          order_tab  [TABLE_ENTRIES];
  logic                      hidden_tab [TABLE_ENTRIES];
  logic [RANK_W-1:0]         rank_tab   [TABLE_ENTRIES];
  bit                        loaded     [TABLE_ENTRIES];
  int unsigned               sel_total;
  int unsigned               atoms_per_frame = 1;
  int unsigned               frames_stored = 1;
  int unsigned               active_frame = 0;

  apso_out_t   expected_q [$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned hits_seen = 0;
  int          cluster_x;
  int          cluster_y;

  function automatic int unsigned frame_base();
    int unsigned fc;
    fc = (frames_stored == 0) ? 1 : frames_stored;
    return (active_frame % fc) * atoms_per_frame;
  endfunction

  function automatic int unsigned scan_end();
    int unsigned e;
    e = frame_base() + atoms_per_frame;
    return (e > TABLE_ENTRIES) ? TABLE_ENTRIES : e;
  endfunction

  function automatic void bump_sel();
    if (sel_total < 1024) sel_total++;
  endfunction

  function automatic apso_out_t predict_selection(apso_in_t it);
    apso_out_t   r;
    int unsigned b, e, best, best_ord, old;
    bit          have;
    longint      dx, dy, rr;
    r = '0;
    b = frame_base();
    e = scan_end();
    have = 0;
    best = 0;
    best_ord = 0;
    case (it.command)
      CMD_WRITE: begin
        atom_x_tab[it.entry_index] = it.atom_x;
        atom_y_tab[it.entry_index] = it.atom_y;
        radius_tab[it.entry_index] = it.atom_radius;
        order_tab[it.entry_index]  = it.atom_depth_order;
        hidden_tab[it.entry_index] = it.atom_hidden;
        rank_tab[it.entry_index]   = '0;
        loaded[it.entry_index]     = 1;
      end
      CMD_PICK: begin
        for (int unsigned t = b; t < e; t++) begin
          if (!hidden_tab[t]) begin
            dx = longint'(it.point_x) - longint'(atom_x_tab[t]);
            dy = longint'(it.point_y) - longint'(atom_y_tab[t]);
            rr = longint'(radius_tab[t]);
            if (dx * dx + dy * dy <= rr * rr && (!have || order_tab[t] < best_ord)) begin
              have = 1;
              best = t;
              best_ord = 32'(order_tab[t]);
            end
          end
        end
        if (have) begin
          r.found = 1'b1;
          r.hit_atom = IDX_W'(best - b);
          old = 32'(rank_tab[best]);
          if (old != 0) begin
            for (int unsigned t = b; t < e; t++)
              if (t != best && rank_tab[t] > old) rank_tab[t]--;
            rank_tab[best] = '0;
            if (sel_total > 0) sel_total--;
          end else begin
            bump_sel();
            rank_tab[best] = RANK_W'(sel_total);
            r.hit_rank = RANK_W'(sel_total);
          end
        end
      end
      CMD_REGION: begin
        for (int unsigned t = b; t < e; t++) begin
          if (atom_x_tab[t] >= it.point_x && atom_x_tab[t] <= it.end_x &&
              atom_y_tab[t] >= it.point_y && atom_y_tab[t] <= it.end_y) begin
            r.found = 1'b1;
            if (rank_tab[t] == 0) begin
              bump_sel();
              rank_tab[t] = RANK_W'(sel_total);
            end
          end
        end
      end
      default: ;
    endcase
    r.selected_count = CNT_W'(sel_total);
    return r;
  endfunction

  // Sends one command beat; start is left high so back-to-back beats need no toggle.
  task automatic send_beat(apso_in_t it, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(predict_selection(it));
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk_i);
    while (expected_q.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int unsigned val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CNT_W'(val);
    case (idx)
      CFG_ATOM_COUNT:  atoms_per_frame = val & 11'h7FF;
      CFG_FRAME_COUNT: frames_stored = val & 11'h7FF;
      default:         active_frame = val & 10'h3FF;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic apso_in_t mk_write(int idx, int x, int y, int rad, int ord, bit hid);
    apso_in_t it;
    it = '0;
    it.command = CMD_WRITE;
    it.entry_index = IDX_W'(idx);
    it.atom_x = COORD_W'(x);
    it.atom_y = COORD_W'(y);
    it.atom_radius = RAD_W'(rad);
    it.atom_depth_order = ORD_W'(ord);
    it.atom_hidden = hid;
    return it;
  endfunction

  function automatic apso_in_t mk_scan(logic [1:0] c, int sx, int sy, int ex, int ey);
    apso_in_t it;
    it = '0;
    it.command = c;
    it.point_x = COORD_W'(sx);
    it.point_y = COORD_W'(sy);
    it.end_x = COORD_W'(ex);
    it.end_y = COORD_W'(ey);
    return it;
  endfunction

  function automatic int near(int c, int spread);
    int v;
    v = c + $urandom_range(2 * spread) - spread;
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  always @(posedge clk_i) begin
    apso_out_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", result_o);
      end else begin
        want = expected_q.pop_front();
        beats_checked++;
        if (result_o.found) hits_seen++;
        if (result_o.found !== want.found || result_o.hit_atom !== want.hit_atom ||
            result_o.hit_rank !== want.hit_rank ||
            result_o.selected_count !== want.selected_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at beat %0d: expected %p, got %p", beats_checked, want, result_o);
        end
      end
    end
  end

  task automatic test_directed_picks();
    cfg_write(CFG_ATOM_COUNT, 4);
    cfg_write(CFG_FRAME_COUNT, 3);
    cfg_write(CFG_CURRENT_FRAME, 4);
    send_beat(mk_write(4, 100, 100, 50, 7, 0), 0);
    send_beat(mk_write(5, 110, 100, 50, 7, 0), 0);
    send_beat(mk_write(6, 120, 100, 50, 3, 1), 0);
    send_beat(mk_write(7, 32767, -32768, 4095, 1023, 0), 0);
    send_beat(mk_scan(CMD_PICK, 105, 100, 0, 0), 0);
    send_beat(mk_scan(CMD_PICK, 32767, -32768, 0, 0), 1);
    send_beat(mk_scan(CMD_PICK, 150, 100, 0, 0), 0);
    send_beat(mk_scan(CMD_PICK, 105, 100, 0, 0), 2);
    send_beat(mk_scan(CMD_PICK, -32768, 32767, 0, 0), 0);
    send_beat(mk_scan(CMD_REGION, -32768, -32768, 32767, 32767), 0);
    send_beat(mk_scan(CMD_REGION, 200, 0, 100, 200), 0);
    send_beat(mk_write(5, 110, 100, 0, 0, 0), 0);
    send_beat(mk_scan(CMD_PICK, 110, 100, 0, 0), 0);
    send_beat(mk_scan(CMD_PICK, 110, 100, 0, 0), 0);
    send_beat(mk_scan(CMD_UNUSED, 1, 2, 3, 4), 3);
    send_beat(mk_write(1023, -1, -1, 4095, 0, 1), 0);
  endtask

  task automatic test_config_extremes();
    cfg_write(CFG_ATOM_COUNT, 1024);
    cfg_write(CFG_FRAME_COUNT, 2);
    cfg_write(CFG_CURRENT_FRAME, 1);
    send_beat(mk_scan(CMD_PICK, -1, -1, 0, 0), 0);
    send_beat(mk_scan(CMD_REGION, -32768, -32768, 32767, 32767), 0);
    cfg_write(CFG_ATOM_COUNT, 1);
    cfg_write(CFG_FRAME_COUNT, 1024);
    cfg_write(CFG_CURRENT_FRAME, 1023);
    send_beat(mk_scan(CMD_REGION, -1, -1, -1, -1), 0);
    send_beat(mk_write(1023, -1, -1, 4095, 0, 0), 0);
    send_beat(mk_scan(CMD_PICK, 4094, -1, 0, 0), 0);
    cfg_write(CFG_FRAME_COUNT, 0);
    cfg_write(CFG_CURRENT_FRAME, 0);
    send_beat(mk_write(0, 0, 0, 1, 0, 0), 0);
    send_beat(mk_scan(CMD_PICK, 1, 0, 0, 0), 0);
    cfg_write(CFG_ATOM_COUNT, 0);
    send_beat(mk_scan(CMD_PICK, 0, 0, 0, 0), 0);
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    apso_in_t    it;
    int unsigned b, e, roll, t, gap;
    int          first_unloaded;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        cfg_write(CFG_ATOM_COUNT, $urandom_range(12, 1));
        cfg_write(CFG_FRAME_COUNT, $urandom_range(4, 1));
        cfg_write(CFG_CURRENT_FRAME, $urandom_range(1023));
        cluster_x = $urandom_range(60000) - 30000;
        cluster_y = $urandom_range(60000) - 30000;
      end
      b = frame_base();
      e = scan_end();
      first_unloaded = -1;
      for (int unsigned s = b; s < e; s++)
        if (!loaded[s] && first_unloaded < 0) first_unloaded = s;
      roll = $urandom_range(99);
      t = (e > b) ? $urandom_range(e - 1, b) : 0;
      if (roll < 35 || (roll < 95 && first_unloaded >= 0)) begin
        it = mk_write((first_unloaded >= 0) ? first_unloaded :
                      ($urandom_range(6) == 0) ? $urandom_range(1023) :
                      (e > b) ? t : $urandom_range(1023),
                      near(cluster_x, 64), near(cluster_y, 64), $urandom_range(80),
                      $urandom_range(1023), $urandom_range(4) == 0);
        if ($urandom_range(7) == 0) begin
          it.atom_x = COORD_W'($urandom);
          it.atom_y = COORD_W'($urandom);
          it.atom_radius = RAD_W'($urandom);
        end
      end else if (roll < 70 && e > b) begin
        it = mk_scan(CMD_PICK, near(int'(atom_x_tab[t]), 40), near(int'(atom_y_tab[t]), 40),
                     0, 0);
        if ($urandom_range(9) == 0) begin
          it.point_x = COORD_W'($urandom);
          it.point_y = COORD_W'($urandom);
        end
      end else if (roll < 95) begin
        it = mk_scan(CMD_REGION, near(cluster_x, 100), near(cluster_y, 100),
                     near(cluster_x, 100), near(cluster_y, 100));
        if ($urandom_range(7) == 0) begin
          it.point_x = COORD_W'($urandom);
          it.point_y = COORD_W'($urandom);
          it.end_x = COORD_W'($urandom);
          it.end_y = COORD_W'($urandom);
        end
      end else begin
        it = mk_write($urandom_range(1023), near(0, 32767), near(0, 32767),
                      $urandom_range(4095), $urandom_range(1023), $urandom_range(1) == 1);
        it.point_x = COORD_W'($urandom);
        it.point_y = COORD_W'($urandom);
        it.end_x = COORD_W'($urandom);
        it.end_y = COORD_W'($urandom);
        it.command = CMD_UNUSED;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
      send_beat(it, (k % 40 < 10) ? 0 : gap);
    end
  endtask

  initial begin
    sel_total = 0;
    foreach (rank_tab[i]) begin
      rank_tab[i] = '0;
      loaded[i] = 0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_picks();
    test_config_extremes();
    test_random_traffic(270);
    wait_idle();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d command beats (%0d results checked, %0d with found set)",
             beats_sent, beats_checked, hits_seen);
    $display("across directed extremes and random frame settings; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("atom_pick_and_selection_order regression: pass");
    end else begin
      $display("atom_pick_and_selection_order regression: fail");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("atom_pick_and_selection_order regression: fail");
    $finish;
  end

endmodule
